### sv/rfd_pkg.sv
package rfd_pkg;

  localparam int unsigned REPORT_DEPTH_DEF  = 256;
  localparam int unsigned COMMAND_DEPTH_DEF = 512;
  localparam int unsigned ENERGY_SLOTS_DEF  = 32;

  localparam logic [7:0] CMD_HDR  [4] = '{8'hFD, 8'hFC, 8'hFB, 8'hFA};
  localparam logic [7:0] DATA_HDR [4] = '{8'hF4, 8'hF3, 8'hF2, 8'hF1};
  localparam logic [31:0] DATA_HDR_WORD = 32'hF4F3F2F1;
  localparam logic [31:0] DATA_FTR_WORD = 32'hF8F7F6F5;

  localparam logic [15:0] CMD_READ_PARAM = 16'h0008;
  localparam logic [15:0] PID_MAX_DIST   = 16'h0001;
  localparam logic [7:0]  PID_NONE_ZERO  = 8'h00;
  localparam logic [7:0]  PID_NONE_ONE   = 8'h01;
  localparam logic [7:0]  PID_NONE_ACK   = 8'h06;

  localparam int unsigned HDR_LEN     = 4;
  localparam int unsigned MIN_FRAME   = 8;
  localparam int unsigned MIN_REPORT  = 9;
  localparam int unsigned ENERGY_BASE = 9;
  localparam int unsigned CMD_CAP     = 12;  // command bytes 4..15 kept in flops
  localparam int unsigned RPT_CAP     = 5;   // report bytes 4..8 kept in flops

  typedef enum logic [1:0] {
    KIND_PARAM  = 2'd0,
    KIND_DIST   = 2'd1,
    KIND_ENERGY = 2'd2
  } rfd_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_FETCH,
    ST_WAIT,
    ST_SEND
  } rfd_state_e;

  typedef struct packed {
    rfd_kind_e   result_kind;
    logic        last_of_run;
    logic [15:0] command_code;
    logic [15:0] parameter_id;
    logic        ack_good;
    logic [63:0] raw_value;
    logic [7:0]  detection_code;
    logic [15:0] target_distance;
    logic [15:0] report_length;
    logic [31:0] energy_word;
    logic        max_distance_known;
    logic [31:0] max_distance_tenths;
  } rfd_result_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] tenths;
  } rfd_max_t;

  typedef struct packed {
    logic        is_cmd;
    logic [15:0] cmd;
    logic [15:0] pid;
    logic        ack;
    logic [63:0] raw;
    logic [7:0]  det;
    logic [15:0] tdist;
    logic [15:0] rlen;
  } rfd_evt_t;

endpackage

### sv/rfd_rx_if.sv
interface rfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### sv/rfd_res_if.sv
interface rfd_res_if
  import rfd_pkg::*;
();
  logic        valid;
  logic        ready;
  rfd_result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### sv/rfd_mem.sv
module rfd_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/rfd_frame.sv
module rfd_frame
  import rfd_pkg::*;
#(
  parameter int unsigned REPORT_DEPTH  = REPORT_DEPTH_DEF,
  parameter int unsigned COMMAND_DEPTH = COMMAND_DEPTH_DEF,
  localparam int unsigned RFW = $clog2(REPORT_DEPTH + 1),
  localparam int unsigned CFW = $clog2(COMMAND_DEPTH + 1),
  localparam int unsigned RAW = $clog2(REPORT_DEPTH)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           acc_i,
  input  logic [7:0]     byte_i,
  output logic           mem_we_o,
  output logic [RAW-1:0] mem_waddr_o,
  output logic [7:0]     mem_wdata_o,
  output logic           evt_v_o,
  output rfd_evt_t       evt_o,
  output logic [RFW-1:0] evt_len_o,
  output rfd_max_t       max_o
);

  logic [1:0]     cm_q, cm_d, dm_q, dm_d;
  logic           in_cmd_q, in_cmd_d, in_rep_q, in_rep_d;
  logic [RFW-1:0] rfill_q, rfill_d, rnf;
  logic [CFW-1:0] cfill_q, cfill_d, cnf;
  logic [31:0]    last4_q, last4_d;
  logic [7:0]     rb_q [RPT_CAP];
  logic [7:0]     rb_d [RPT_CAP];
  logic [7:0]     cb_q [CMD_CAP];
  logic [7:0]     cb_d [CMD_CAP];
  rfd_max_t       max_q, max_d;
  logic           evt_v_q, evt_v_d;
  rfd_evt_t       evt_q, evt_d;
  logic [RFW-1:0] elen_q, elen_d;
  logic           consumed;
  logic [16:0]    rexp, cexp;
  logic [15:0]    dlen, ccmd, cpid, cack;

  always_comb begin
    cm_d     = cm_q;
    dm_d     = dm_q;
    in_cmd_d = in_cmd_q;
    in_rep_d = in_rep_q;
    rfill_d  = rfill_q;
    cfill_d  = cfill_q;
    last4_d  = last4_q;
    rb_d     = rb_q;
    cb_d     = cb_q;
    max_d    = max_q;
    evt_v_d  = 1'b0;
    evt_d    = evt_q;
    elen_d   = elen_q;
    consumed = 1'b0;
    mem_we_o = 1'b0;
    rnf      = rfill_q;
    cnf      = cfill_q;
    rexp     = '0;
    cexp     = '0;
    dlen     = {cb_d[1], cb_d[0]};
    ccmd     = {cb_d[3], cb_d[2]};
    cpid     = {cb_d[5], cb_d[4]};
    cack     = {cb_d[7], cb_d[6]};

    if (acc_i) begin
      // Command header matcher has first claim on the byte.
      if (!in_cmd_q) begin
        if (byte_i == CMD_HDR[cm_q]) begin
          consumed = 1'b1;
          if (cm_q == 2'd3) begin
            in_cmd_d = 1'b1;
            cfill_d  = CFW'(HDR_LEN);
            cm_d     = '0;
          end else begin
            cm_d = cm_q + 2'd1;
          end
        end else begin
          cm_d = '0;
        end
      end

      if (!consumed && !in_rep_q) begin
        if (byte_i == DATA_HDR[dm_q]) begin
          consumed = 1'b1;
          if (dm_q == 2'd3) begin
            in_rep_d = 1'b1;
            rfill_d  = RFW'(HDR_LEN);
            last4_d  = DATA_HDR_WORD;
            dm_d     = '0;
          end else begin
            dm_d = dm_q + 2'd1;
          end
        end else begin
          dm_d = '0;
        end
      end

      if (!consumed && in_rep_q) begin
        if (rfill_q < RFW'(REPORT_DEPTH)) begin
          mem_we_o = 1'b1;
          rnf      = rfill_q + RFW'(1);
          last4_d  = {last4_q[23:0], byte_i};
          for (int i = 0; i < RPT_CAP; i++) begin
            if (rfill_q == RFW'(HDR_LEN + i)) rb_d[i] = byte_i;
          end
        end
        rfill_d = rnf;
        rexp    = 17'(MIN_FRAME) + {1'b0, rb_d[3], rb_d[2]};
        if (rnf >= RFW'(MIN_FRAME) && 17'(rnf) >= rexp && last4_d == DATA_FTR_WORD) begin
          in_rep_d = 1'b0;
          rfill_d  = '0;
          // Drop short reports and zero length words.
          if (rnf >= RFW'(MIN_REPORT) && {rb_d[1], rb_d[0]} != 16'd0) begin
            evt_v_d     = 1'b1;
            elen_d      = rnf;
            evt_d       = '0;
            evt_d.det   = rb_d[2];
            evt_d.tdist = {rb_d[4], rb_d[3]};
            evt_d.rlen  = {rb_d[1], rb_d[0]};
          end
        end
      end else if (!consumed && in_cmd_q) begin
        if (cfill_q < CFW'(COMMAND_DEPTH)) begin
          cnf = cfill_q + CFW'(1);
          for (int i = 0; i < CMD_CAP; i++) begin
            if (cfill_q == CFW'(HDR_LEN + i)) cb_d[i] = byte_i;
          end
        end
        dlen    = {cb_d[1], cb_d[0]};
        ccmd    = {cb_d[3], cb_d[2]};
        cpid    = {cb_d[5], cb_d[4]};
        cack    = {cb_d[7], cb_d[6]};
        cfill_d = cnf;
        cexp    = 17'(MIN_FRAME) + {1'b0, dlen};
        if (cnf >= CFW'(MIN_FRAME) && 17'(cnf) >= cexp) begin
          in_cmd_d     = 1'b0;
          cfill_d      = '0;
          evt_v_d      = 1'b1;
          evt_d        = '0;
          evt_d.is_cmd = 1'b1;
          evt_d.cmd    = ccmd;
          if (dlen >= 16'd8) begin
            evt_d.pid = cpid;
            evt_d.ack = (cack == 16'd0);
            evt_d.raw = {32'd0, cb_d[11], cb_d[10], cb_d[9], cb_d[8]};
            if (cack == 16'd0 && ccmd == CMD_READ_PARAM && cpid == PID_MAX_DIST) begin
              max_d.valid  = 1'b1;
              max_d.tenths = {cb_d[11], cb_d[10], cb_d[9], cb_d[8]};
            end
          end else if (dlen >= 16'd2) begin
            if (cb_d[4] != PID_NONE_ZERO && cb_d[4] != PID_NONE_ONE &&
                cb_d[4] != PID_NONE_ACK) begin
              evt_d.pid = {8'd0, cb_d[4]};
            end
            // Short value: data length minus one bytes from byte nine on.
            for (int i = 0; i < 6; i++) begin
              if (16'(i) < dlen - 16'd1) evt_d.raw[8*i +: 8] = cb_d[5 + i];
            end
          end
        end
      end
    end
  end

  assign mem_waddr_o = rfill_q[RAW-1:0];
  assign mem_wdata_o = byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cm_q     <= '0;
      dm_q     <= '0;
      in_cmd_q <= 1'b0;
      in_rep_q <= 1'b0;
      rfill_q  <= '0;
      cfill_q  <= '0;
      max_q    <= '0;
      evt_v_q  <= 1'b0;
    end else begin
      cm_q     <= cm_d;
      dm_q     <= dm_d;
      in_cmd_q <= in_cmd_d;
      in_rep_q <= in_rep_d;
      rfill_q  <= rfill_d;
      cfill_q  <= cfill_d;
      max_q    <= max_d;
      evt_v_q  <= evt_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last4_q <= last4_d;
    rb_q    <= rb_d;
    cb_q    <= cb_d;
    evt_q   <= evt_d;
    elen_q  <= elen_d;
  end

  assign evt_v_o   = evt_v_q;
  assign evt_o     = evt_q;
  assign evt_len_o = elen_q;
  assign max_o     = max_q;

endmodule

### sv/rfd_emit.sv
module rfd_emit
  import rfd_pkg::*;
#(
  parameter int unsigned REPORT_DEPTH = REPORT_DEPTH_DEF,
  parameter int unsigned ENERGY_SLOTS = ENERGY_SLOTS_DEF,
  localparam int unsigned RFW = $clog2(REPORT_DEPTH + 1),
  localparam int unsigned RAW = $clog2(REPORT_DEPTH),
  localparam int unsigned PW  = $clog2(REPORT_DEPTH + 8),
  localparam int unsigned SW  = $clog2(ENERGY_SLOTS + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           evt_v_i,
  input  rfd_evt_t       evt_i,
  input  logic [RFW-1:0] evt_len_i,
  input  rfd_max_t       max_i,
  output logic [RAW-1:0] mem_raddr_o,
  input  logic [7:0]     mem_rdata_i,
  output logic           idle_o,
  rfd_res_if.source      res_o
);

  rfd_state_e  state_q, state_d;
  logic [PW-1:0] pos_q, rd_pos, len_x;
  logic [SW-1:0] words_q;
  logic [1:0]    k_q, lane_q;
  logic          rdv_q;
  logic [31:0]   word_q;
  logic          out_v_q;
  rfd_result_t   out_q, load_val;
  logic          free, load, head_last, word_more;

  assign free      = !out_v_q || res_o.ready;
  assign len_x     = PW'(evt_len_i);
  assign head_last = !(PW'(ENERGY_BASE + 3) < len_x);
  assign word_more = (pos_q + PW'(7) < len_x) && (words_q < SW'(ENERGY_SLOTS - 1));
  assign rd_pos    = pos_q + PW'(k_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (evt_v_i) state_d = ST_HEAD;
      ST_HEAD:  if (free) state_d = (evt_i.is_cmd || head_last) ? ST_IDLE : ST_FETCH;
      ST_FETCH: if (k_q == 2'd3) state_d = ST_WAIT;
      ST_WAIT:  state_d = ST_SEND;
      ST_SEND:  if (free) state_d = word_more ? ST_FETCH : ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    load     = free && (state_q == ST_HEAD || state_q == ST_SEND);
    load_val = '0;
    unique case (state_q)
      ST_HEAD: begin
        if (evt_i.is_cmd) begin
          load_val.result_kind  = KIND_PARAM;
          load_val.last_of_run  = 1'b1;
          load_val.command_code = evt_i.cmd;
          load_val.parameter_id = evt_i.pid;
          load_val.ack_good     = evt_i.ack;
          load_val.raw_value    = evt_i.raw;
        end else begin
          load_val.result_kind     = KIND_DIST;
          load_val.last_of_run     = head_last;
          load_val.detection_code  = evt_i.det;
          load_val.target_distance = evt_i.tdist;
          load_val.report_length   = evt_i.rlen;
        end
      end
      ST_SEND: begin
        load_val.result_kind = KIND_ENERGY;
        load_val.last_of_run = !word_more;
        load_val.energy_word = word_q;
      end
      default: load_val.result_kind = KIND_PARAM;
    endcase
    load_val.max_distance_known  = max_i.valid;
    load_val.max_distance_tenths = max_i.tenths;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      words_q <= '0;
      k_q     <= '0;
      rdv_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rdv_q   <= (state_q == ST_FETCH);
      if (state_q == ST_HEAD) begin
        pos_q   <= PW'(ENERGY_BASE);
        words_q <= '0;
        k_q     <= '0;
      end else if (state_q == ST_FETCH) begin
        k_q <= k_q + 2'd1;
      end else if (state_q == ST_SEND && free) begin
        pos_q   <= pos_q + PW'(4);
        words_q <= words_q + SW'(1);
        k_q     <= '0;
      end
      if (load) begin
        out_v_q <= 1'b1;
      end else if (res_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= k_q;
    if (rdv_q) begin
      word_q[8*lane_q +: 8] <= mem_rdata_i;
    end
    if (load) begin
      out_q <= load_val;
    end
  end

  assign mem_raddr_o   = rd_pos[RAW-1:0];
  assign idle_o        = (state_q == ST_IDLE);
  assign res_o.valid   = out_v_q;
  assign res_o.payload = out_q;

endmodule

### sv/radar_frame_deframer_core.sv
// Radar frame deframer: splits the sensor byte stream into command and data
// frames and reports what they carry.
//
// rx_i: one received byte per beat (valid/ready). res_o: one result per beat,
// a parameter response, a distance report, or a raw energy word, with
// last_of_run set on the final result caused by a byte.
//
// A byte that completes no frame leaves input ready; the next byte can be
// taken on the following cycle. A completing byte holds off input while the
// event is registered and the first result is loaded. Each energy word after
// a distance report takes four one-byte reads of the report store (one read
// port, registered read data), a wait for the last read to land, then the
// send, which waits while the output register is full and not taken.
// Command bytes 4..15 and report bytes 4..8 sit in flops; energy words come
// from the report store.
//
// Reset clears matchers, fill counts, the maximum-distance state and the
// output register; store contents stay undefined and are read only after
// being written within the current frame. When the receiver stalls, the
// output register holds its beat and the emitter waits; input stays blocked
// only while a run of results is still being produced.
module radar_frame_deframer_core
  import rfd_pkg::*;
#(
  parameter int unsigned REPORT_DEPTH  = REPORT_DEPTH_DEF,
  parameter int unsigned COMMAND_DEPTH = COMMAND_DEPTH_DEF,
  parameter int unsigned ENERGY_SLOTS  = ENERGY_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rfd_rx_if.sink     rx_i,
  rfd_res_if.source  res_o
);

  localparam int unsigned RFW = $clog2(REPORT_DEPTH + 1);
  localparam int unsigned RAW = $clog2(REPORT_DEPTH);

  logic           acc;
  logic           mem_we;
  logic [RAW-1:0] mem_waddr, mem_raddr;
  logic [7:0]     mem_wdata, mem_rdata;
  logic           evt_v;
  rfd_evt_t       evt;
  logic [RFW-1:0] evt_len;
  rfd_max_t       max_s;
  logic           emit_idle;

  // Take a byte only when no run of results is pending.
  assign rx_i.ready = emit_idle && !evt_v;
  assign acc        = rx_i.valid && rx_i.ready;

  rfd_frame #(
    .REPORT_DEPTH (REPORT_DEPTH),
    .COMMAND_DEPTH(COMMAND_DEPTH)
  ) u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .byte_i     (rx_i.rx_byte),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .evt_v_o    (evt_v),
    .evt_o      (evt),
    .evt_len_o  (evt_len),
    .max_o      (max_s)
  );

  // Report store: one write port from the gatherer, one read port for words.
  rfd_mem #(
    .DEPTH(REPORT_DEPTH),
    .AW   (RAW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  rfd_emit #(
    .REPORT_DEPTH(REPORT_DEPTH),
    .ENERGY_SLOTS(ENERGY_SLOTS)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt_v_i    (evt_v),
    .evt_i      (evt),
    .evt_len_i  (evt_len),
    .max_i      (max_s),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata),
    .idle_o     (emit_idle),
    .res_o      (res_o)
  );

  // A parameter response always ends its run.
  a_param_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.payload.result_kind == KIND_PARAM |-> res_o.payload.last_of_run)
    else $error("parameter response without last_of_run");

  // Once a maximum distance is known it stays known.
  a_max_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(max_s.valid))
    else $error("maximum distance lost");

  // Every completed frame event starts an emission run.
  a_evt_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_v |=> !emit_idle)
    else $error("frame event not picked up");

endmodule
